/* rtl/spd_pkg.sv */
// stroke packet deframer package: header layout constants, status and kind codes,
// result record and the push record between the parser and the result queue
// no dependencies
`default_nettype none

package spd_pkg;

  localparam int unsigned POS_W     = 21;
  localparam int unsigned HDR_LEN   = 18;
  localparam int unsigned MAGIC_END = 4;
  localparam int unsigned PEER_END  = 8;
  localparam int unsigned STRK_END  = 12;
  localparam int unsigned SEQ_END   = 14;
  localparam int unsigned CNT_END   = 16;
  localparam int unsigned CLOSED_AT = 16;
  localparam int unsigned SMP_BYTES = 16;
  localparam int unsigned OFF_W     = $clog2(SMP_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_TRUNCATED = 2'd3
  } spd_status_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_STATUS = 1'b1
  } spd_kind_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] sample_x;
    logic [31:0] sample_y;
    logic [31:0] sample_z;
    logic [31:0] sample_pressure;
    logic [15:0] sample_index;
    logic [31:0] peer_number;
    logic [31:0] stroke_number;
    logic [15:0] sequence_number;
    logic        is_closed;
    logic [1:0]  status;
    logic        end_of_run;
  } spd_result_t;

  typedef struct packed {
    logic [1:0]  count;
    spd_result_t first;
    spd_result_t second;
  } spd_push_t;

endpackage

`default_nettype wire

/* rtl/spd_parser.sv */
// byte parser: header capture, magic check, sample assembly and status build
// depends on spd_pkg
`default_nettype none

module spd_parser import spd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_magic_word,
  input  wire logic        beat,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_packet,
  output spd_push_t        push
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      magic_word_r, magic_word_nxt;
  logic [31:0]      magic_r, magic_nxt;
  logic [31:0]      peer_r, peer_nxt;
  logic [31:0]      stroke_r, stroke_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [15:0]      count_r, count_nxt;
  logic             closed_r, closed_nxt;
  logic [127:0]     smp_r, smp_nxt;
  logic [15:0]      done_r, done_nxt;
  logic             bad_r, bad_nxt;

  logic [OFF_W-1:0] off;
  logic [31:0]      magic_shifted;
  logic             smp_emit;
  spd_status_t      st;
  spd_result_t      smp_res, st_res;

  assign off           = pos_r[OFF_W-1:0] - OFF_W'(HDR_LEN);
  assign magic_shifted = {data_byte, magic_r[31:8]};

  always_comb begin
    pos_nxt        = pos_r;
    magic_word_nxt = cfg_we ? cfg_magic_word : magic_word_r;
    magic_nxt      = magic_r;
    peer_nxt       = peer_r;
    stroke_nxt     = stroke_r;
    seq_nxt        = seq_r;
    count_nxt      = count_r;
    closed_nxt     = closed_r;
    smp_nxt        = smp_r;
    done_nxt       = done_r;
    bad_nxt        = bad_r;
    smp_emit       = 1'b0;
    st             = ST_OK;
    smp_res        = '0;
    st_res         = '0;
    push           = '0;

    if (beat) begin
      if (pos_r < POS_W'(MAGIC_END)) begin
        magic_nxt = magic_shifted;
        if (pos_r == POS_W'(MAGIC_END - 1)) begin
          bad_nxt = (magic_shifted != magic_word_r);
        end
      end else if (pos_r < POS_W'(PEER_END)) begin
        peer_nxt = {data_byte, peer_r[31:8]};
      end else if (pos_r < POS_W'(STRK_END)) begin
        stroke_nxt = {data_byte, stroke_r[31:8]};
      end else if (pos_r < POS_W'(SEQ_END)) begin
        seq_nxt = {data_byte, seq_r[15:8]};
      end else if (pos_r < POS_W'(CNT_END)) begin
        count_nxt = {data_byte, count_r[15:8]};
      end else if (pos_r == POS_W'(CLOSED_AT)) begin
        closed_nxt = |data_byte;
      end else if (pos_r >= POS_W'(HDR_LEN) && done_r < count_r) begin
        smp_nxt = {data_byte, smp_r[127:8]};
        if (off == OFF_W'(SMP_BYTES - 1)) begin
          smp_emit = ~bad_r;
          done_nxt = done_r + 16'd1;
        end
      end

      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end

      smp_res.kind            = KIND_SAMPLE;
      smp_res.sample_x        = smp_nxt[31:0];
      smp_res.sample_y        = smp_nxt[63:32];
      smp_res.sample_z        = smp_nxt[95:64];
      smp_res.sample_pressure = smp_nxt[127:96];
      smp_res.sample_index    = done_r;
      smp_res.peer_number     = peer_r;
      smp_res.stroke_number   = stroke_r;
      smp_res.sequence_number = seq_r;
      smp_res.is_closed       = closed_r;

      if (pos_nxt < POS_W'(HDR_LEN)) begin
        st = ST_SHORT;
      end else if (bad_nxt) begin
        st = ST_BAD_MAGIC;
      end else if (done_nxt < count_nxt) begin
        st = ST_TRUNCATED;
      end else begin
        st = ST_OK;
      end

      st_res.kind       = KIND_STATUS;
      st_res.status     = st;
      st_res.end_of_run = 1'b1;
      if (st == ST_OK) begin
        st_res.peer_number     = peer_nxt;
        st_res.stroke_number   = stroke_nxt;
        st_res.sequence_number = seq_nxt;
        st_res.is_closed       = closed_nxt;
      end

      if (smp_emit) begin
        push.first = smp_res;
        if (end_of_packet) begin
          push.second = st_res;
          push.count  = 2'd2;
        end else begin
          push.count  = 2'd1;
        end
      end else if (end_of_packet) begin
        push.first = st_res;
        push.count = 2'd1;
      end

      if (end_of_packet) begin
        pos_nxt    = '0;
        magic_nxt  = '0;
        peer_nxt   = '0;
        stroke_nxt = '0;
        seq_nxt    = '0;
        count_nxt  = '0;
        closed_nxt = 1'b0;
        done_nxt   = '0;
        bad_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      magic_word_r <= '0;
      magic_r      <= '0;
      peer_r       <= '0;
      stroke_r     <= '0;
      seq_r        <= '0;
      count_r      <= '0;
      closed_r     <= 1'b0;
      done_r       <= '0;
      bad_r        <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      magic_word_r <= magic_word_nxt;
      magic_r      <= magic_nxt;
      peer_r       <= peer_nxt;
      stroke_r     <= stroke_nxt;
      seq_r        <= seq_nxt;
      count_r      <= count_nxt;
      closed_r     <= closed_nxt;
      done_r       <= done_nxt;
      bad_r        <= bad_nxt;
    end
  end

  // sample assembly holds payload only
  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
  end

endmodule

`default_nettype wire

/* rtl/spd_outq.sv */
// result queue: takes up to two results a cycle, hands out one per beat
// depends on spd_pkg
`default_nettype none

module spd_outq import spd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire spd_push_t push,
  output logic       space,
  output logic       out_valid,
  input  wire logic  out_ready,
  output spd_result_t head
);

  spd_result_t        mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, wr_nxt;
  logic [QPTR_W-1:0]  rd_r, rd_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               pop;

  // room for the two results one byte can give
  assign space     = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign head      = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push.count);
    rd_nxt  = rd_r + QPTR_W'(pop);
    cnt_nxt = cnt_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_r + QPTR_W'(1)] <= push.second;
    end
  end

endmodule

`default_nettype wire

/* rtl/stroke_packet_deframer.sv */
// stroke packet deframer top level: parser feeding a four-entry result queue
// depends on spd_pkg, spd_parser, spd_outq
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    data_byte, end_of_packet
//   out_     out  out_valid / out_ready  kind, sample fields, header fields, status
//   cfg_     in   cfg_valid / cfg_ready  magic_word
//
// one byte a cycle while in_ready; results leave the queue one a cycle while out_ready
// in_ready drops only while the queue lacks room for two results
// cfg_ready is always high; synchronous active-low reset clears packet state and magic
`default_nettype none

module stroke_packet_deframer import spd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_magic_word,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_packet,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [31:0]      out_sample_x,
  output logic [31:0]      out_sample_y,
  output logic [31:0]      out_sample_z,
  output logic [31:0]      out_sample_pressure,
  output logic [15:0]      out_sample_index,
  output logic [31:0]      out_peer_number,
  output logic [31:0]      out_stroke_number,
  output logic [15:0]      out_sequence_number,
  output logic             out_is_closed,
  output logic [1:0]       out_status,
  output logic             out_end_of_run
);

  spd_push_t   push;
  spd_result_t head;
  logic        space;
  logic        beat;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign beat      = in_valid & space;

  spd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid),
    .cfg_magic_word (cfg_magic_word),
    .beat           (beat),
    .data_byte      (in_data_byte),
    .end_of_packet  (in_end_of_packet),
    .push           (push)
  );

  spd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind            = head.kind;
  assign out_sample_x        = head.sample_x;
  assign out_sample_y        = head.sample_y;
  assign out_sample_z        = head.sample_z;
  assign out_sample_pressure = head.sample_pressure;
  assign out_sample_index    = head.sample_index;
  assign out_peer_number     = head.peer_number;
  assign out_stroke_number   = head.stroke_number;
  assign out_sequence_number = head.sequence_number;
  assign out_is_closed       = head.is_closed;
  assign out_status          = head.status;
  assign out_end_of_run      = head.end_of_run;

endmodule

`default_nettype wire

/* sim/stroke_packet_deframer_test.sv */
// self-checking testbench for stroke_packet_deframer: directed and random packets
// with random idling on both channels, checked beat by beat against a local predictor
// depends on spd_pkg and the stroke_packet_deframer rtl
`default_nettype none

module stroke_packet_deframer_test;
  import spd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_magic_word = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [31:0] out_sample_x;
  logic [31:0] out_sample_y;
  logic [31:0] out_sample_z;
  logic [31:0] out_sample_pressure;
  logic [15:0] out_sample_index;
  logic [31:0] out_peer_number;
  logic [31:0] out_stroke_number;
  logic [15:0] out_sequence_number;
  logic        out_is_closed;
  logic [1:0]  out_status;
  logic        out_end_of_run;

  stroke_packet_deframer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_magic_word      (cfg_magic_word),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_end_of_packet    (in_end_of_packet),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_sample_x        (out_sample_x),
    .out_sample_y        (out_sample_y),
    .out_sample_z        (out_sample_z),
    .out_sample_pressure (out_sample_pressure),
    .out_sample_index    (out_sample_index),
    .out_peer_number     (out_peer_number),
    .out_stroke_number   (out_stroke_number),
    .out_sequence_number (out_sequence_number),
    .out_is_closed       (out_is_closed),
    .out_status          (out_status),
    .out_end_of_run      (out_end_of_run)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]      magic_setting = '0;
  logic [POS_W-1:0] byte_pos;
  logic [31:0]      magic_acc;
  logic [31:0]      peer_acc;
  logic [31:0]      stroke_acc;
  logic [15:0]      seq_acc;
  logic [15:0]      count_acc;
  logic             closed_acc;
  logic [31:0]      word_acc [4];
  logic [15:0]      samples_seen;
  logic             magic_mismatch;

  spd_result_t expected_results [$];
  logic [7:0]  frame_bytes [$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_len = 0;

  task automatic clear_frame_state();
    byte_pos = '0;
    magic_acc = '0;
    peer_acc = '0;
    stroke_acc = '0;
    seq_acc = '0;
    count_acc = '0;
    closed_acc = 1'b0;
    for (int i = 0; i < 4; i++) word_acc[i] = '0;
    samples_seen = '0;
    magic_mismatch = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    spd_result_t     r;
    spd_status_t     st;
    logic [POS_W-1:0] rel;
    logic [3:0]      off;
    if (byte_pos < MAGIC_END) begin
      magic_acc = {b, magic_acc[31:8]};
      if (byte_pos == MAGIC_END - 1) magic_mismatch = (magic_acc != magic_setting);
    end else if (byte_pos < PEER_END) begin
      peer_acc = {b, peer_acc[31:8]};
    end else if (byte_pos < STRK_END) begin
      stroke_acc = {b, stroke_acc[31:8]};
    end else if (byte_pos < SEQ_END) begin
      seq_acc = {b, seq_acc[15:8]};
    end else if (byte_pos < CNT_END) begin
      count_acc = {b, count_acc[15:8]};
    end else if (byte_pos == CLOSED_AT) begin
      closed_acc = (b != 8'h00);
    end else if (byte_pos >= HDR_LEN && samples_seen < count_acc) begin
      rel = byte_pos - POS_W'(HDR_LEN);
      off = rel[3:0];
      word_acc[off[3:2]][off[1:0]*8 +: 8] = b;
      if (off == 4'hF) begin
        if (!magic_mismatch) begin
          r = '0;
          r.kind = KIND_SAMPLE;
          r.sample_x = word_acc[0];
          r.sample_y = word_acc[1];
          r.sample_z = word_acc[2];
          r.sample_pressure = word_acc[3];
          r.sample_index = samples_seen;
          r.peer_number = peer_acc;
          r.stroke_number = stroke_acc;
          r.sequence_number = seq_acc;
          r.is_closed = closed_acc;
          r.status = ST_OK;
          r.end_of_run = 1'b0;
          expected_results.push_back(r);
        end
        samples_seen = samples_seen + 16'd1;
      end
    end

    if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;

    if (last) begin
      if (byte_pos < HDR_LEN) st = ST_SHORT;
      else if (magic_mismatch) st = ST_BAD_MAGIC;
      else if (samples_seen < count_acc) st = ST_TRUNCATED;
      else st = ST_OK;
      r = '0;
      r.kind = KIND_STATUS;
      if (st == ST_OK) begin
        r.peer_number = peer_acc;
        r.stroke_number = stroke_acc;
        r.sequence_number = seq_acc;
        r.is_closed = closed_acc;
      end
      r.status = st;
      r.end_of_run = 1'b1;
      expected_results.push_back(r);
      clear_frame_state();
    end
  endtask

  // result checker
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    spd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual kind %b status %h",
                 $time, out_kind, out_status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("sample_x", want.sample_x, out_sample_x);
        check_field("sample_y", want.sample_y, out_sample_y);
        check_field("sample_z", want.sample_z, out_sample_z);
        check_field("sample_pressure", want.sample_pressure, out_sample_pressure);
        check_field("sample_index", 32'(want.sample_index), 32'(out_sample_index));
        check_field("peer_number", want.peer_number, out_peer_number);
        check_field("stroke_number", want.stroke_number, out_stroke_number);
        check_field("sequence_number", 32'(want.sequence_number), 32'(out_sequence_number));
        check_field("is_closed", 32'(want.is_closed), 32'(out_is_closed));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("end_of_run", 32'(want.end_of_run), 32'(out_end_of_run));
      end
    end
  end

  // result receiver with random and long hold-offs
  initial begin
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        gap = hold_len;
        hold_req = 1'b0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 11) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_packet <= last;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) send_beat(frame_bytes[i], i == n - 1);
    frame_bytes.delete();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_magic(input logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_magic_word <= value;
    do @(posedge clk); while (!cfg_ready);
    magic_setting = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic push_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) frame_bytes.push_back(value[i*8 +: 8]);
  endtask

  task automatic push_header(input logic [31:0] magic, input logic [31:0] peer,
                             input logic [31:0] stroke, input logic [15:0] seq,
                             input logic [15:0] count, input logic [7:0] closed,
                             input logic [7:0] rsv);
    push_le(magic, 4);
    push_le(peer, 4);
    push_le(stroke, 4);
    push_le(32'(seq), 2);
    push_le(32'(count), 2);
    push_le(32'(closed), 1);
    push_le(32'(rsv), 1);
  endtask

  task automatic push_sample(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] p);
    push_le(x, 4);
    push_le(y, 4);
    push_le(z, 4);
    push_le(p, 4);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // directed tests
  task automatic test_short_header();
    frame_bytes.push_back(8'hFF);
    send_frame();
    push_header(magic_setting, '0, '0, '0, '0, 8'h00, 8'h00);
    void'(frame_bytes.pop_back());
    send_frame();
    settle();
  endtask

  task automatic test_header_only();
    push_header(magic_setting, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'h0000, 8'h80, 8'hFF);
    send_frame();
    push_header(magic_setting, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 8'h00, 8'h00);
    send_frame();
    settle();
  endtask

  task automatic test_bad_magic();
    push_header(magic_setting ^ 32'h0000_0001, 32'h1234_5678, 32'h9ABC_DEF0, 16'h0102,
                16'h0001, 8'h01, 8'h00);
    push_sample(32'hFFFF_FFFF, 32'h0, 32'h3F80_0000, 32'h8000_0000);
    send_frame();
    push_header(magic_setting ^ 32'h8000_0000, 32'h1, 32'h2, 16'h3, 16'h0000, 8'h00, 8'h00);
    send_frame();
    settle();
  endtask

  task automatic test_truncated();
    push_header(magic_setting, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h8001, 16'h0002, 8'h01, 8'h55);
    push_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h3F80_0000, 32'h8000_0000);
    push_random(7);
    send_frame();
    push_header(magic_setting, 32'h0, 32'h1, 16'h2, 16'hFFFF, 8'hFF, 8'h00);
    push_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h3F00_0000);
    send_frame();
    settle();
  endtask

  task automatic test_sample_on_last_byte();
    push_header(magic_setting, 32'h0BAD_F00D, 32'h0000_0042, 16'h0007, 16'h0002, 8'h00, 8'h00);
    push_sample(32'h3F80_0000, 32'hBF80_0000, 32'h0000_0001, 32'h3F7F_FFFF);
    push_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame();
    settle();
  endtask

  task automatic test_trailing_bytes();
    push_header(magic_setting, 32'hCAFE_0001, 32'h0000_FFFF, 16'h00FF, 16'h0001, 8'h02, 8'h00);
    push_sample(32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h3E80_0000);
    repeat (5) frame_bytes.push_back(8'hFF);
    send_frame();
    settle();
  endtask

  task automatic test_backpressure();
    bit save_tx;
    bit save_rx;
    save_tx = tx_idle;
    save_rx = rx_idle;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_len = 200;
    hold_req = 1'b1;
    push_header(magic_setting, $urandom, $urandom, 16'h0101, 16'h0008, 8'h01, 8'h00);
    push_random(8 * SMP_BYTES);
    send_frame();
    // sender waits here for every outstanding result
    settle();
    tx_idle = save_tx;
    rx_idle = save_rx;
  endtask

  task automatic send_random_packet();
    int unsigned shape;
    int unsigned count;
    int unsigned nsmp;
    int unsigned cut;
    logic [31:0] m;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      push_random($urandom_range(1, 24));
      send_frame();
    end else begin
      if (shape == 1) m = magic_setting ^ (32'h1 << $urandom_range(0, 31));
      else if (shape == 2) m = $urandom;
      else m = magic_setting;
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 65535) : $urandom_range(0, 3);
      push_header(m, $urandom, $urandom, 16'($urandom), 16'(count),
                  ($urandom_range(0, 1) ? 8'h00 : 8'($urandom)), 8'($urandom));
      case ($urandom_range(0, 5))
        0: begin
          nsmp = (count > 0) ? ((count > 3) ? 3 : count - 1) : 0;
          push_random(nsmp * SMP_BYTES + $urandom_range(0, 15));
        end
        1: begin
          cut = $urandom_range(1, 17);
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
        default: begin
          nsmp = (count > 3) ? $urandom_range(0, 2) : count;
          push_random(nsmp * SMP_BYTES);
          if ($urandom_range(0, 2) == 0) push_random($urandom_range(1, 6));
        end
      endcase
      send_frame();
    end
  endtask

  task automatic test_random_traffic(input logic [31:0] magic, input int unsigned nbytes);
    int unsigned start;
    write_magic(magic);
    start = bytes_sent;
    while (bytes_sent - start < nbytes) send_random_packet();
    settle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_header();
    test_header_only();
    write_magic(32'hA5C3_0F01);
    test_bad_magic();
    test_truncated();
    test_sample_on_last_byte();
    test_trailing_bytes();
    test_backpressure();

    test_random_traffic(32'hFFFF_FFFF, 160);
    test_random_traffic($urandom, 160);
    test_random_traffic(32'h0000_0000, 150);

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("stroke_packet_deframer_test passed");
    end else begin
      $display("stroke_packet_deframer_test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t timeout, %0d results outstanding", $time, expected_results.size());
    $display("stroke_packet_deframer_test failed");
    $finish;
  end

endmodule

`default_nettype wire
